// ----- src/assert_macros.svh -----
// Assertion helpers included by the centroid RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check an implication in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/gstc_pkg.sv -----
package gstc_pkg;

  localparam int MatrixDim  = 16;
  localparam int CoordBits  = 12;
  // wide enough for a 30-bit moment shifted left by 14
  localparam int DivBits    = 44;

  localparam logic [2:0] RegWidth     = 3'd0;
  localparam logic [2:0] RegHeight    = 3'd1;
  localparam logic [2:0] RegColumns   = 3'd2;
  localparam logic [2:0] RegRows      = 3'd3;
  localparam logic [2:0] RegThreshold = 3'd4;
  localparam logic [2:0] RegInvert    = 3'd5;

  // Unsigned restoring divider request
  typedef struct packed {
    logic               start;
    logic [DivBits-1:0] num;
    logic [DivBits-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivBits-1:0] quot;
    logic [DivBits-1:0] rem;
  } div_rsp_t;

endpackage

// ----- src/grid_sample_threshold_centroid.sv -----
// Grid-sampled thresholded weighted centroid.
// Input channel: one RGBA pixel per beat (in_valid_i / in_stall_o) in raster
// order; frame_start marks the first pixel of a frame.
// Output channel: out_valid_o / out_stall_i. Each sample point yields a
// matrix beat (result_kind 0); the last pixel of a frame also yields a
// summary beat (result_kind 1, last 1) with channel means, mean weight and
// the normalized centroid.
// Configuration: cfg_we_i / cfg_idx_i / cfg_data_i, written while idle.
// Timing: grid placement and sample arithmetic run through one shared
// 44-bit serial divider; each division is a start, 44 steps and a done.
// A sample-point pixel needs four divisions, and a new beat is taken only
// once the sequencer is back in idle. The last pixel of a frame adds up to
// seven divisions. The divider sets the rate unless the output stalls.
// A result waits in the output register while stalled; the next pixel is
// still taken and holds in the sequencer when its own result is ready.
// Reset clears position, frame sums, held centroid and registers to their
// reset values; no clearing pass is needed.
module grid_sample_threshold_centroid import gstc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         alpha_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic [7:0]         matrix_index_o,
  output logic [9:0]         point_value_o,
  output logic [7:0]         avg_alpha_o,
  output logic [7:0]         avg_red_o,
  output logic [7:0]         avg_green_o,
  output logic [7:0]         avg_blue_o,
  output logic signed [14:0] centroid_x_o,
  output logic signed [14:0] centroid_y_o,
  output logic [9:0]         mean_weight_o,
  output logic               centroid_valid_o,
  output logic               last_o
);

  `include "assert_macros.svh"

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDiv   = 4'd1;
  localparam logic [3:0] StWait  = 4'd2;
  localparam logic [3:0] StPoint = 4'd3;
  localparam logic [3:0] StSum   = 4'd4;
  localparam logic [3:0] StOutP  = 4'd5;
  localparam logic [3:0] StOutS  = 4'd6;
  localparam logic [3:0] StNorm  = 4'd7;

  // Division jobs in order
  localparam logic [3:0] JGapC = 4'd0;
  localparam logic [3:0] JPosC = 4'd1;
  localparam logic [3:0] JGapR = 4'd2;
  localparam logic [3:0] JPosR = 4'd3;
  localparam logic [3:0] JCx   = 4'd4;
  localparam logic [3:0] JCy   = 4'd5;
  localparam logic [3:0] JMw   = 4'd6;
  localparam logic [3:0] JA    = 4'd7;
  localparam logic [3:0] JR    = 4'd8;
  localparam logic [3:0] JG    = 4'd9;
  localparam logic [3:0] JB    = 4'd10;

  logic [11:0] width_q, height_q;
  logic [4:0]  cols_q, rows_q;
  logic [7:0]  thr_q;
  logic        inv_q;

  logic [3:0]  state_q, state_d;
  logic [3:0]  job_q, job_d;
  logic [CoordBits-1:0] col_q, col_d, row_q, row_d;
  logic [15:0] csum_q [4];
  logic [15:0] csum_d [4];
  logic [17:0] wsum_q, wsum_d;
  logic [29:0] wx_q, wx_d, wy_q, wy_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [14:0] hcx_q, hcx_d, hcy_q, hcy_d;
  logic [9:0]  hmw_q, hmw_d;

  logic [7:0]  r_q, g_q, b_q, a_q;
  logic [11:0] gap_q, gap_d;
  logic        onc_q, onc_d, onr_q, onr_d;
  logic [4:0]  kc_q, kc_d, kr_q, kr_d;
  logic        eof_q, eof_d, valid_q, valid_d;
  logic [9:0]  val_q, val_d;
  logic [7:0]  avg_q [4];
  logic [7:0]  avg_d [4];
  logic [29:0] prod_q, prod_d;

  logic        ov_q, ov_d;
  logic        okind_q, okind_d, olast_q, olast_d, ocv_q, ocv_d;
  logic [7:0]  oidx_q, oidx_d;
  logic [9:0]  oval_q, oval_d, omw_q, omw_d;
  logic [7:0]  oavg_q [4];
  logic [7:0]  oavg_d [4];
  logic [14:0] ocx_q, ocx_d, ocy_q, ocy_d;

  div_req_t dreq;
  div_rsp_t drsp;

  gstc_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  logic [11:0] w_eff, h_eff, off_c;
  logic [4:0]  nc, nr;
  logic [9:0]  lw;
  logic [12:0] nxt_col, nxt_row;
  logic        accept, out_take;
  logic [DivBits-1:0] mq;

  always_comb begin
    w_eff  = (width_q == '0) ? 12'd1 : width_q;
    h_eff  = (height_q == '0) ? 12'd1 : height_q;
    nc     = (cols_q == '0) ? 5'd1 : ((cols_q > 5'(MatrixDim)) ? 5'(MatrixDim) : cols_q);
    nr     = (rows_q == '0) ? 5'd1 : ((rows_q > 5'(MatrixDim)) ? 5'(MatrixDim) : rows_q);
    lw     = 10'(r_q) + 10'(g_q) + 10'(b_q);
    if (inv_q) lw = 10'd765 - lw;
    off_c  = {1'b0, gap_q[11:1]};
    nxt_col = 13'(col_q) + 13'd1;
    nxt_row = 13'(row_q) + 13'd1;
    accept   = in_valid_i && !in_stall_o;
    out_take = ov_q && !out_stall_i;
    mq = drsp.quot;
  end

  assign in_stall_o = (state_q != StIdle);

  // Sequencer
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    col_d = col_q; row_d = row_q;
    csum_d = csum_q; wsum_d = wsum_q; wx_d = wx_q; wy_d = wy_q; cnt_d = cnt_q;
    hcx_d = hcx_q; hcy_d = hcy_q; hmw_d = hmw_q;
    gap_d = gap_q; onc_d = onc_q; onr_d = onr_q; kc_d = kc_q; kr_d = kr_q;
    eof_d = eof_q; valid_d = valid_q; val_d = val_q; avg_d = avg_q;
    prod_d = prod_q;
    ov_d = ov_q; okind_d = okind_q; olast_d = olast_q; ocv_d = ocv_q;
    oidx_d = oidx_q; oval_d = oval_q; omw_d = omw_q; oavg_d = oavg_q;
    ocx_d = ocx_q; ocy_d = ocy_q;
    dreq = '0;

    if (out_take) ov_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (frame_start_i) begin
            col_d = '0; row_d = '0;
            for (int c = 0; c < 4; c++) csum_d[c] = '0;
            wsum_d = '0; wx_d = '0; wy_d = '0; cnt_d = '0;
          end
          job_d = JGapC;
          state_d = StDiv;
        end
      end
      StDiv: begin
        dreq.start = 1'b1;
        case (job_q)
          JGapC: begin dreq.num = DivBits'(w_eff); dreq.den = DivBits'(nc); end
          JPosC: begin
            dreq.num = DivBits'(col_q - off_c);
            dreq.den = DivBits'(gap_q);
          end
          JGapR: begin dreq.num = DivBits'(h_eff); dreq.den = DivBits'(nr); end
          JPosR: begin
            dreq.num = DivBits'(row_q - off_c);
            dreq.den = DivBits'(gap_q);
          end
          JCx: begin dreq.num = DivBits'({wx_q, 14'd0}); dreq.den = prod_q == '0 ?
                 DivBits'(1) : DivBits'(prod_q); end
          JCy: begin dreq.num = DivBits'({wy_q, 14'd0}); dreq.den = prod_q == '0 ?
                 DivBits'(1) : DivBits'(prod_q); end
          JMw: begin dreq.num = DivBits'(wsum_q); dreq.den = DivBits'(cnt_q); end
          JA:  begin dreq.num = DivBits'(csum_q[0]); dreq.den = DivBits'(cnt_q); end
          JR:  begin dreq.num = DivBits'(csum_q[1]); dreq.den = DivBits'(cnt_q); end
          JG:  begin dreq.num = DivBits'(csum_q[2]); dreq.den = DivBits'(cnt_q); end
          default: begin dreq.num = DivBits'(csum_q[3]); dreq.den = DivBits'(cnt_q); end
        endcase
        state_d = StWait;
      end
      StWait: begin
        if (drsp.done) begin
          state_d = StDiv;
          case (job_q)
            JGapC: begin
              gap_d = (mq[11:0] == '0) ? 12'd1 : mq[11:0];
              job_d = JPosC;
              if (col_q < {1'b0, gap_d[11:1]}) begin
                onc_d = 1'b0;
                job_d = JGapR;
              end
            end
            JPosC: begin
              onc_d = (drsp.rem == '0) && (mq < DivBits'(nc));
              kc_d  = mq[4:0];
              job_d = JGapR;
            end
            JGapR: begin
              gap_d = (mq[11:0] == '0) ? 12'd1 : mq[11:0];
              job_d = JPosR;
              if (row_q < {1'b0, gap_d[11:1]}) begin
                onr_d = 1'b0;
                state_d = StPoint;
              end
            end
            JPosR: begin
              onr_d = (drsp.rem == '0) && (mq < DivBits'(nr));
              kr_d  = mq[4:0];
              state_d = StPoint;
            end
            JCx: begin
              if (mq > DivBits'(32767)) hcx_d = 15'd16383;
              else if (mq[15:0] >= 16'd16384) hcx_d = 15'(mq[15:0] - 16'd16384);
              else hcx_d = 15'(mq[15:0]) - 15'd16384;
              prod_d = 30'(wsum_q) * 30'(h_eff[11:1] == '0 ? 12'd1 :
                       {1'b0, h_eff[11:1]});
              job_d = JCy;
            end
            JCy: begin
              if (mq > DivBits'(32767)) hcy_d = 15'd16383;
              else if (mq[15:0] >= 16'd16384) hcy_d = 15'(mq[15:0] - 16'd16384);
              else hcy_d = 15'(mq[15:0]) - 15'd16384;
              job_d = JMw;
            end
            JMw: begin
              // a wrapped point count of zero gives zero means
              if (cnt_q == '0) begin
                hmw_d = '0;
                state_d = StOutS;
              end else begin
                hmw_d = mq[9:0];
                job_d = JA;
              end
            end
            JA: begin avg_d[0] = mq[7:0]; job_d = JR; end
            JR: begin avg_d[1] = mq[7:0]; job_d = JG; end
            JG: begin avg_d[2] = mq[7:0]; job_d = JB; end
            default: begin avg_d[3] = mq[7:0]; state_d = StOutS; end
          endcase
        end
      end
      StPoint: begin
        // accumulate the sample, stage the point beat
        eof_d = (nxt_col >= 13'(w_eff)) && (nxt_row >= 13'(h_eff));
        if (onc_q && onr_q) begin
          val_d = (lw >= 10'(thr_q) * 10'd3) ? lw : 10'd0;
          csum_d[0] = csum_q[0] + 16'(a_q);
          csum_d[1] = csum_q[1] + 16'(r_q);
          csum_d[2] = csum_q[2] + 16'(g_q);
          csum_d[3] = csum_q[3] + 16'(b_q);
          cnt_d  = cnt_q + 9'd1;
          wsum_d = wsum_q + 18'(val_d);
          wx_d   = wx_q + 30'(col_q) * 30'(val_d);
          wy_d   = wy_q + 30'(row_q) * 30'(val_d);
          state_d = StOutP;
        end else begin
          state_d = StSum;
        end
      end
      StOutP: begin
        if (!ov_q || out_take) begin
          ov_d = 1'b1; okind_d = 1'b0; olast_d = 1'b0; ocv_d = 1'b0;
          oidx_d = {kc_q[3:0], kr_q[3:0]};
          oval_d = val_q; omw_d = '0; ocx_d = '0; ocy_d = '0;
          for (int c = 0; c < 4; c++) oavg_d[c] = '0;
          state_d = StSum;
        end
      end
      StSum: begin
        if (!eof_q) begin
          if (nxt_col >= 13'(w_eff)) begin
            col_d = '0; row_d = nxt_row[CoordBits-1:0];
          end else begin
            col_d = nxt_col[CoordBits-1:0];
          end
          state_d = StIdle;
        end else begin
          valid_d = wsum_q != '0;
          if (cnt_q == '0) begin
            for (int c = 0; c < 4; c++) avg_d[c] = '0;
          end
          if (wsum_q != '0) begin
            prod_d = 30'(wsum_q) * 30'(w_eff[11:1] == '0 ? 12'd1 :
                     {1'b0, w_eff[11:1]});
            job_d = JCx;
            state_d = StNorm;
          end else if (cnt_q != '0) begin
            job_d = JA;
            state_d = StDiv;
          end else begin
            state_d = StOutS;
          end
        end
      end
      StNorm: begin
        // wait here while the denominator product registers
        state_d = StDiv;
      end
      StOutS: begin
        if (!ov_q || out_take) begin
          ov_d = 1'b1; okind_d = 1'b1; olast_d = 1'b1; ocv_d = valid_q;
          oidx_d = '0; oval_d = '0;
          omw_d = hmw_q; ocx_d = hcx_q; ocy_d = hcy_q;
          oavg_d = avg_q;
          for (int c = 0; c < 4; c++) csum_d[c] = '0;
          wsum_d = '0; wx_d = '0; wy_d = '0; cnt_d = '0;
          col_d = '0; row_d = '0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd640; height_q <= 12'd480;
      cols_q <= 5'd8; rows_q <= 5'd8; thr_q <= 8'd64; inv_q <= 1'b0;
      state_q <= StIdle; job_q <= JGapC;
      col_q <= '0; row_q <= '0;
      for (int c = 0; c < 4; c++) csum_q[c] <= '0;
      wsum_q <= '0; wx_q <= '0; wy_q <= '0; cnt_q <= '0;
      hcx_q <= '0; hcy_q <= '0; hmw_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegWidth:     width_q  <= cfg_data_i;
          RegHeight:    height_q <= cfg_data_i;
          RegColumns:   cols_q   <= cfg_data_i[4:0];
          RegRows:      rows_q   <= cfg_data_i[4:0];
          RegThreshold: thr_q    <= cfg_data_i[7:0];
          RegInvert:    inv_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      state_q <= state_d; job_q <= job_d;
      col_q <= col_d; row_q <= row_d;
      csum_q <= csum_d; wsum_q <= wsum_d; wx_q <= wx_d; wy_q <= wy_d;
      cnt_q <= cnt_d;
      hcx_q <= hcx_d; hcy_q <= hcy_d; hmw_q <= hmw_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q <= red_i; g_q <= green_i; b_q <= blue_i; a_q <= alpha_i;
    end
    gap_q <= gap_d; onc_q <= onc_d; onr_q <= onr_d; kc_q <= kc_d; kr_q <= kr_d;
    eof_q <= eof_d; valid_q <= valid_d; val_q <= val_d; avg_q <= avg_d;
    prod_q <= prod_d;
    okind_q <= okind_d; olast_q <= olast_d; ocv_q <= ocv_d;
    oidx_q <= oidx_d; oval_q <= oval_d; omw_q <= omw_d; oavg_q <= oavg_d;
    ocx_q <= ocx_d; ocy_q <= ocy_d;
  end

  assign out_valid_o      = ov_q;
  assign result_kind_o    = okind_q;
  assign matrix_index_o   = oidx_q;
  assign point_value_o    = oval_q;
  assign avg_alpha_o      = oavg_q[0];
  assign avg_red_o        = oavg_q[1];
  assign avg_green_o      = oavg_q[2];
  assign avg_blue_o       = oavg_q[3];
  assign centroid_x_o     = ocx_q;
  assign centroid_y_o     = ocy_q;
  assign mean_weight_o    = omw_q;
  assign centroid_valid_o = ocv_q;
  assign last_o           = olast_q;

  `ASSERT_IMPL(a_stall_busy, state_q != StIdle, in_stall_o)
  `ASSERT_IMPL(a_last_kind, out_valid_o, last_o == result_kind_o)
  `ASSERT_NEXT(a_accept_starts, accept, state_q == StDiv)

endmodule

// ----- src/gstc_div.sv -----
module gstc_div import gstc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivBits-1:0] quot_q, quot_d, rem_q, rem_d, den_q, den_d;
  logic [5:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DivBits:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[DivBits-1]} - {1'b0, den_q};
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'(DivBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit per cycle
      if (!trial[DivBits]) begin
        rem_d = trial[DivBits-1:0];
        quot_d = {quot_q[DivBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivBits-2:0], quot_q[DivBits-1]};
        quot_d = {quot_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- sim/grid_sample_threshold_centroid_test.sv -----
module grid_sample_threshold_centroid_test;
  import gstc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit  = 20000;
  localparam int SettleCyc  = 600;
  localparam int HoldOffCyc = 3000;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_start;
  } pixel_t;

  typedef struct {
    logic        kind;
    logic [7:0]  index;
    logic [9:0]  value;
    logic [7:0]  avg [4];
    logic signed [14:0] cx;
    logic signed [14:0] cy;
    logic [9:0]  mean_w;
    logic        cvalid;
    logic        last;
  } grid_result_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_start;
    int         point_value;  // -1: taken from the predictor
  } pixel_row_t;

  typedef struct {
    int width, height, cols, rows, thresh, invert;
    int items, tx_pct, rx_pct;
    bit start_frame, hold_off, drain_each;
  } phase_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_idx_i = RegWidth;
  logic [11:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        red_i = '0, green_i = '0, blue_i = '0, alpha_i = '0;
  logic              frame_start_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              result_kind_o;
  logic [7:0]        matrix_index_o;
  logic [9:0]        point_value_o;
  logic [7:0]        avg_alpha_o, avg_red_o, avg_green_o, avg_blue_o;
  logic signed [14:0] centroid_x_o, centroid_y_o;
  logic [9:0]        mean_weight_o;
  logic              centroid_valid_o;
  logic              last_o;

  grid_sample_threshold_centroid i_dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  longint unsigned width_r, height_r, cols_r, rows_r, thresh_r, invert_r;
  longint unsigned pos_col, pos_row, npoints, light_sum, x_moment, y_moment;
  longint unsigned chan_sum [4];
  logic [14:0]     held_cx, held_cy;
  logic [9:0]      held_mean;

  grid_result_t expected_results [$];
  int  errors = 0;
  int  tx_pct = 0, rx_pct = 0;
  bit  rx_hold = 1'b0;
  int  idle_cycles = 0;

  function automatic void clear_sums();
    for (int c = 0; c < 4; c++) chan_sum[c] = 0;
    light_sum = 0;
    x_moment  = 0;
    y_moment  = 0;
    npoints   = 0;
  endfunction

  function automatic longint unsigned points_of(longint unsigned n);
    if (n == 0) return 1;
    if (n > MatrixDim) return MatrixDim;
    return n;
  endfunction

  function automatic bit grid_slot(longint unsigned pos, longint unsigned size,
                                   longint unsigned n, output longint unsigned slot);
    longint unsigned gap, off, d;
    gap  = size / n;
    slot = 0;
    if (gap == 0) gap = 1;
    off = gap / 2;
    if (pos < off) return 1'b0;
    d = pos - off;
    if (d % gap != 0 || d / gap >= n) return 1'b0;
    slot = d / gap;
    return 1'b1;
  endfunction

  function automatic logic [14:0] q14_centroid(longint unsigned moment,
                                               longint unsigned total,
                                               longint unsigned size);
    longint unsigned half;
    longint          q;
    half = size / 2;
    if (half == 0) half = 1;
    q = longint'((moment << 14) / (total * half)) - 16384;
    if (q > 16383) q = 16383;
    if (q < -16384) q = -16384;
    return q[14:0];
  endfunction

  function automatic void blank(output grid_result_t r);
    r.kind = 0; r.index = 0; r.value = 0;
    for (int c = 0; c < 4; c++) r.avg[c] = 0;
    r.cx = 0; r.cy = 0; r.mean_w = 0; r.cvalid = 0; r.last = 0;
  endfunction

  // Advance the centroid predictor by one pixel; return the number of results.
  function automatic int centroid_pixel(pixel_t p, output grid_result_t res [2]);
    longint unsigned w, h, kc, kr, lw, val;
    longint unsigned comp [4];
    int n;
    n = 0;
    w = (width_r == 0) ? 1 : width_r;
    h = (height_r == 0) ? 1 : height_r;
    comp[0] = p.alpha; comp[1] = p.red; comp[2] = p.green; comp[3] = p.blue;
    blank(res[0]);
    blank(res[1]);
    if (p.frame_start) begin
      pos_col = 0;
      pos_row = 0;
      clear_sums();
    end
    if (grid_slot(pos_col, w, points_of(cols_r), kc) &&
        grid_slot(pos_row, h, points_of(rows_r), kr)) begin
      lw = p.red + p.green + p.blue;
      if (invert_r != 0) lw = 765 - lw;
      val = (lw >= 3 * thresh_r) ? lw : 0;
      for (int c = 0; c < 4; c++) chan_sum[c] = (chan_sum[c] + comp[c]) & 16'hFFFF;
      npoints   = (npoints + 1) & 9'h1FF;
      light_sum = (light_sum + val) & 18'h3FFFF;
      x_moment  = (x_moment + pos_col * val) & 30'h3FFFFFFF;
      y_moment  = (y_moment + pos_row * val) & 30'h3FFFFFFF;
      res[0].index = kc * MatrixDim + kr;
      res[0].value = val[9:0];
      n = 1;
    end
    if (pos_col + 1 >= w && pos_row + 1 >= h) begin
      if (light_sum != 0) begin
        held_cx   = q14_centroid(x_moment, light_sum, w);
        held_cy   = q14_centroid(y_moment, light_sum, h);
        held_mean = (npoints != 0) ? 10'(light_sum / npoints) : '0;
      end
      res[n].kind = 1;
      for (int c = 0; c < 4; c++) res[n].avg[c] = (npoints != 0) ? 8'(chan_sum[c] / npoints) : '0;
      res[n].cx     = held_cx;
      res[n].cy     = held_cy;
      res[n].mean_w = held_mean;
      res[n].cvalid = (light_sum != 0);
      res[n].last   = 1;
      n++;
      clear_sums();
      pos_col = 0;
      pos_row = 0;
    end else if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row = (pos_row + 1) & 12'hFFF;
    end else begin
      pos_col = (pos_col + 1) & 12'hFFF;
    end
    return n;
  endfunction

  task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    grid_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        cmp("result_kind", e.kind, result_kind_o);
        cmp("matrix_index", e.index, matrix_index_o);
        cmp("point_value", e.value, point_value_o);
        cmp("avg_alpha", e.avg[0], avg_alpha_o);
        cmp("avg_red", e.avg[1], avg_red_o);
        cmp("avg_green", e.avg[2], avg_green_o);
        cmp("avg_blue", e.avg[3], avg_blue_o);
        cmp("centroid_x", e.cx, centroid_x_o);
        cmp("centroid_y", e.cy, centroid_y_o);
        cmp("mean_weight", e.mean_w, mean_weight_o);
        cmp("centroid_valid", e.cvalid, centroid_valid_o);
        cmp("last", e.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= rx_hold || ($urandom_range(99) < rx_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[11:0];
    @(posedge clk_i);
    case (idx)
      RegWidth:     width_r  = value & 12'hFFF;
      RegHeight:    height_r = value & 12'hFFF;
      RegColumns:   cols_r   = value & 5'h1F;
      RegRows:      rows_r   = value & 5'h1F;
      RegThreshold: thresh_r = value & 8'hFF;
      RegInvert:    invert_r = value & 1;
      default: ;
    endcase
  endtask

  task automatic configure(phase_t ph);
    write_reg(RegWidth, ph.width);
    write_reg(RegHeight, ph.height);
    write_reg(RegColumns, ph.cols);
    write_reg(RegRows, ph.rows);
    write_reg(RegThreshold, ph.thresh);
    write_reg(RegInvert, ph.invert);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until all results are in, then let a pointless pixel finish its divisions.
  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Offer one pixel and wait for its beat; leave valid high for the caller.
  task automatic send_pixel(pixel_t p, int typed_value);
    grid_result_t res [2];
    int n;
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    red_i         <= p.red;
    green_i       <= p.green;
    blue_i        <= p.blue;
    alpha_i       <= p.alpha;
    frame_start_i <= p.frame_start;
    do @(posedge clk_i); while (in_stall_o);
    n = centroid_pixel(p, res);
    if (typed_value >= 0 && n > 0 && res[0].kind == 0) res[0].value = typed_value;
    for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
  endtask

  function automatic pixel_t random_pixel(bit fs);
    pixel_t p;
    logic [7:0] ch [4];
    int mode;
    mode = $urandom_range(3);
    for (int c = 0; c < 4; c++) begin
      case (mode)
        0: ch[c] = $urandom_range(255);
        1: ch[c] = $urandom_range(255, 180);
        2: ch[c] = $urandom_range(60);
        default: ch[c] = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
    end
    p.red = ch[0]; p.green = ch[1]; p.blue = ch[2]; p.alpha = ch[3];
    p.frame_start = fs;
    return p;
  endfunction

  // 2x2 grid on a 2x2 frame: every pixel is a sample point
  pixel_row_t directed [15] = '{
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 765},
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 0},
    '{8'd85,  8'd85,  8'd85,  8'd17,  1'b0, 255},
    '{8'd63,  8'd64,  8'd64,  8'd0,   1'b0, 0},
    '{8'd10,  8'd20,  8'd30,  8'd255, 1'b1, 0},
    '{8'd10,  8'd20,  8'd30,  8'd1,   1'b0, 0},
    '{8'd0,   8'd0,   8'd0,   8'd128, 1'b0, 0},
    '{8'd64,  8'd64,  8'd63,  8'd200, 1'b0, 0},
    '{8'd200, 8'd0,   8'd0,   8'd9,   1'b1, 200},
    '{8'd0,   8'd255, 8'd0,   8'd9,   1'b0, 255},
    '{8'd0,   8'd0,   8'd255, 8'd9,   1'b1, 255},
    '{8'd64,  8'd64,  8'd64,  8'd90,  1'b0, 192},
    '{8'd128, 8'd1,   8'd2,   8'd3,   1'b0, -1},
    '{8'd170, 8'd85,  8'd42,  8'd77,  1'b0, -1},
    '{8'd255, 8'd0,   8'd255, 8'd0,   1'b0, -1}
  };

  phase_t phases [8] = '{
    '{2, 2, 2, 2, 64, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0},
    '{2, 2, 2, 2, 1, 0, 165, 0, 0, 1'b1, 1'b0, 1'b0},
    '{5, 4, 3, 16, 255, 1, 110, 57, 0, 1'b1, 1'b0, 1'b0},
    '{4095, 4095, 16, 16, 128, 1, 30, 0, 0, 1'b1, 1'b0, 1'b0},
    '{3, 2, 0, 31, 0, 0, 110, 0, 57, 1'b0, 1'b0, 1'b0},
    '{8, 6, 16, 1, 100, 0, 120, 22, 57, 1'b1, 1'b0, 1'b0},
    '{0, 3, 5, 2, 30, 1, 120, 22, 22, 1'b1, 1'b1, 1'b0},
    '{3, 4095, 2, 2, 80, 0, 80, 57, 22, 1'b1, 1'b0, 1'b1}
  };

  initial begin
    pixel_t p;
    width_r = 640; height_r = 480; cols_r = 8; rows_r = 8; thresh_r = 64; invert_r = 0;
    pos_col = 0; pos_row = 0;
    clear_sums();
    held_cx = '0; held_cy = '0; held_mean = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(phases[0]);
    foreach (directed[i]) begin
      p.red = directed[i].red; p.green = directed[i].green; p.blue = directed[i].blue;
      p.alpha = directed[i].alpha; p.frame_start = directed[i].frame_start;
      send_pixel(p, directed[i].point_value);
    end
    in_valid_i <= 1'b0;

    for (int ph = 1; ph < 8; ph++) begin
      drain();
      configure(phases[ph]);
      tx_pct = phases[ph].tx_pct;
      rx_pct = phases[ph].rx_pct;
      if (phases[ph].hold_off) begin
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HoldOffCyc) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end
      for (int k = 0; k < phases[ph].items; k++) begin
        // Restart the frame now and then; well-formed frames otherwise.
        send_pixel(random_pixel((k == 0 && phases[ph].start_frame) ||
                                ($urandom_range(99) < 2)), -1);
        if (phases[ph].drain_each && $urandom_range(3) == 0) begin
          in_valid_i <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
    end

    tx_pct = 0;
    rx_pct = 0;
    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
